/* src/arpct_pkg.sv */
// ----------------------------------------------------------------------------
// ARP cache table package
// Shared field widths, command and status codes, and the control and status
// bundles passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package arpct_pkg;

  localparam int CMD_W    = 2;
  localparam int IP_W     = 32;
  localparam int MAC_W    = 48;
  localparam int TICK_W   = 32;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 3;
  localparam int COUNT_W  = 4;

  localparam logic [TICK_W-1:0]  EXPIRY_RST = 32'd60000;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SWEEP  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic first;   // request taken, read entry 0, clear the scan results
    logic scan;    // read the next entry
    logic finish;  // commit the insert and load the result register
  } arpct_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last;  // the entry being read is the last one
    logic out_free;   // result register can take a new result
  } arpct_sts_t;

endpackage

/* src/arpct_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module arpct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/arpct_ctrl.sv */
// ----------------------------------------------------------------------------
// ARP cache table controller
// Sequences one request: accept, scan the entries, drain, commit.
// ----------------------------------------------------------------------------
module arpct_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  arpct_pkg::arpct_sts_t sts,
  output arpct_pkg::arpct_cmd_t cmd
);

  import arpct_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.first = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // hold until the previous result has been taken
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid))
    else $error("stall rose without an accepted request");
`endif

endmodule

/* src/arpct_dp.sv */
// ----------------------------------------------------------------------------
// ARP cache table datapath
// Entry RAM, in-use flags, per-entry evaluation and result register.
// ----------------------------------------------------------------------------
module arpct_dp #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  arpct_pkg::arpct_cmd_t               cmd,
  output arpct_pkg::arpct_sts_t               sts,
  input  logic [arpct_pkg::CMD_W-1:0]         in_cmd,
  input  logic [arpct_pkg::IP_W-1:0]          in_ip_address,
  input  logic [arpct_pkg::MAC_W-1:0]         in_mac_address,
  input  logic                                in_entry_is_static,
  input  logic [arpct_pkg::TICK_W-1:0]        in_now_tick,
  input  logic [arpct_pkg::TICK_W-1:0]        expiry,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [arpct_pkg::STATUS_W-1:0]      out_status,
  output logic [arpct_pkg::MAC_W-1:0]         out_found_mac,
  output logic [arpct_pkg::SLOT_W-1:0]        out_slot_used,
  output logic [arpct_pkg::COUNT_W-1:0]       out_expired_count
);

  import arpct_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int RAM_W = IP_W + MAC_W + TICK_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // request
  logic [CMD_W-1:0]  cmd_r;
  logic [IP_W-1:0]   ip_r;
  logic [MAC_W-1:0]  mac_r;
  logic              is_static_r;
  logic [TICK_W-1:0] now_r;

  // scan
  logic [IDX_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  raddr;
  logic              eval_v_r;
  logic [IDX_W-1:0]  eval_idx_r;
  logic [RAM_W-1:0]  rdata;

  // flags
  logic [TABLE_ENTRIES-1:0] ent_static_r;
  logic [TABLE_ENTRIES-1:0] ent_dynamic_r;

  // scan results
  logic              match_v_r;
  logic [IDX_W-1:0]  match_idx_r;
  logic [MAC_W-1:0]  found_mac_r;
  logic              free_v_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic              vict_v_r;
  logic [IDX_W-1:0]  vict_idx_r;
  logic [TICK_W-1:0] oldest_r;
  logic [COUNT_W-1:0] count_r;

  // evaluation
  logic [IP_W-1:0]   rd_ip;
  logic [MAC_W-1:0]  rd_mac;
  logic [TICK_W-1:0] rd_stamp;
  logic              in_use;
  logic              is_dyn;
  logic [TICK_W-1:0] age;
  logic              do_expire;

  // commit
  logic              tgt_v;
  logic [IDX_W-1:0]  tgt_idx;
  logic              do_write;
  logic [STATUS_W-1:0] res_status;
  logic [MAC_W-1:0]  res_mac;
  logic [SLOT_W-1:0] res_slot;
  logic [COUNT_W-1:0] res_count;

  // output register
  logic               out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [MAC_W-1:0]   out_mac_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [COUNT_W-1:0] out_count_r;

  assign raddr = cmd.first ? '0 : cnt_r;

  arpct_ram #(
    .WIDTH (RAM_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (tgt_idx),
    .wdata ({ip_r, mac_r, now_r}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign rd_ip     = rdata[RAM_W-1 -: IP_W];
  assign rd_mac    = rdata[MAC_W+TICK_W-1 -: MAC_W];
  assign rd_stamp  = rdata[TICK_W-1:0];
  assign in_use    = ent_static_r[eval_idx_r] | ent_dynamic_r[eval_idx_r];
  assign is_dyn    = ent_dynamic_r[eval_idx_r] & ~ent_static_r[eval_idx_r];
  assign age       = now_r - rd_stamp;
  assign do_expire = eval_v_r && (cmd_r == CMD_SWEEP) && is_dyn && (age >= expiry);

  assign sts.scan_last = (cnt_r == LAST_IDX);
  assign sts.out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      cmd_r       <= in_cmd;
      ip_r        <= in_ip_address;
      mac_r       <= in_mac_address;
      is_static_r <= in_entry_is_static;
      now_r       <= in_now_tick;
    end
    if (cmd.first || cmd.scan) begin
      cnt_r <= raddr + IDX_W'(1);
    end
    eval_idx_r <= raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eval_v_r <= 1'b0;
    end else begin
      eval_v_r <= cmd.first || cmd.scan;
    end
  end

  // scan accumulators
  always_ff @(posedge clk) begin
    if (cmd.first) begin
      match_v_r <= 1'b0;
      free_v_r  <= 1'b0;
      vict_v_r  <= 1'b0;
      oldest_r  <= '0;
      count_r   <= '0;
    end else if (eval_v_r) begin
      if (in_use && !match_v_r && (rd_ip == ip_r)) begin
        match_v_r   <= 1'b1;
        match_idx_r <= eval_idx_r;
        found_mac_r <= rd_mac;
      end
      // last free slot wins
      if (!in_use) begin
        free_v_r   <= 1'b1;
        free_idx_r <= eval_idx_r;
      end
      // strictly older only: first entry wins a tie, age zero never qualifies
      if (is_dyn && (age > oldest_r)) begin
        vict_v_r   <= 1'b1;
        vict_idx_r <= eval_idx_r;
        oldest_r   <= age;
      end
      if (do_expire && (count_r != COUNT_MAX)) begin
        count_r <= count_r + COUNT_W'(1);
      end
    end
  end

  // target of an insert: match, then free slot, then victim
  always_comb begin
    tgt_v   = 1'b1;
    tgt_idx = match_idx_r;
    if (!match_v_r) begin
      if (free_v_r) begin
        tgt_idx = free_idx_r;
      end else if (vict_v_r) begin
        tgt_idx = vict_idx_r;
      end else begin
        tgt_v = 1'b0;
      end
    end
  end

  assign do_write = cmd.finish && (cmd_r == CMD_INSERT) && tgt_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_static_r  <= '0;
      ent_dynamic_r <= '0;
    end else if (do_expire) begin
      ent_static_r[eval_idx_r]  <= 1'b0;
      ent_dynamic_r[eval_idx_r] <= 1'b0;
    end else if (do_write) begin
      ent_static_r[tgt_idx]  <= is_static_r;
      ent_dynamic_r[tgt_idx] <= ~is_static_r;
    end
  end

  always_comb begin
    res_status = ST_OK;
    res_mac    = '0;
    res_slot   = '0;
    res_count  = '0;
    case (cmd_r)
      CMD_LOOKUP: begin
        if (match_v_r) begin
          res_mac  = found_mac_r;
          res_slot = SLOT_W'(match_idx_r);
        end else begin
          res_status = ST_MISS;
        end
      end
      CMD_INSERT: begin
        if (tgt_v) begin
          res_slot = SLOT_W'(tgt_idx);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_SWEEP: begin
        res_count = count_r;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status_r <= res_status;
      out_mac_r    <= res_mac;
      out_slot_r   <= res_slot;
      out_count_r  <= res_count;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_mac     = out_mac_r;
  assign out_slot_used     = out_slot_r;
  assign out_expired_count = out_count_r;

`ifndef SYNTHESIS
  a_no_clobber: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result register loaded while a result was pending");

  a_free_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (do_write && !match_v_r && free_v_r) |->
      !(ent_static_r[free_idx_r] || ent_dynamic_r[free_idx_r]))
    else $error("insert into a free slot that is in use");

  a_victim_age: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && vict_v_r) |-> (oldest_r != '0))
    else $error("victim chosen with zero age");
`endif

endmodule

/* src/arp_cache_table_unit.sv */
// ----------------------------------------------------------------------------
// ARP cache table unit
// IPv4-to-MAC cache with static and dynamic entries, insert with replacement
// of the oldest dynamic entry and an aging sweep driven by an expiry register.
// ----------------------------------------------------------------------------
// Scan: the entry RAM is read with one registered read per cycle, entry 0
//   first, and the result is registered after the last read has drained.
// Requests: a new request is taken only once the previous result has been
//   committed, which is later when a finished result is held by out_stall.
// Reset: all entries free, expiry register 60000, no result pending.
module arp_cache_table_unit #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [arpct_pkg::TICK_W-1:0]        cfg_wdata,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [arpct_pkg::CMD_W-1:0]         in_cmd,
  input  logic [arpct_pkg::IP_W-1:0]          in_ip_address,
  input  logic [arpct_pkg::MAC_W-1:0]         in_mac_address,
  input  logic                                in_entry_is_static,
  input  logic [arpct_pkg::TICK_W-1:0]        in_now_tick,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [arpct_pkg::STATUS_W-1:0]      out_status,
  output logic [arpct_pkg::MAC_W-1:0]         out_found_mac,
  output logic [arpct_pkg::SLOT_W-1:0]        out_slot_used,
  output logic [arpct_pkg::COUNT_W-1:0]       out_expired_count
);

  import arpct_pkg::*;

  logic [TICK_W-1:0] expiry_r;
  arpct_cmd_t        cmd;
  arpct_sts_t        sts;

  // Expiry register: the user writes it only while the unit is idle, so no
  // hold is needed against a sweep in progress; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= EXPIRY_RST;
    end else if (cfg_we) begin
      expiry_r <= cfg_wdata;
    end
  end

  // Controller: take a request, step the scan, drain the last read, then
  // commit once the result register is free.
  arpct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: entry RAM, in-use flags, per-entry match, free slot, oldest
  // victim and expiry checks, and the result register.
  arpct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_cmd             (in_cmd),
    .in_ip_address      (in_ip_address),
    .in_mac_address     (in_mac_address),
    .in_entry_is_static (in_entry_is_static),
    .in_now_tick        (in_now_tick),
    .expiry             (expiry_r),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_found_mac      (out_found_mac),
    .out_slot_used      (out_slot_used),
    .out_expired_count  (out_expired_count)
  );

endmodule
